@@ hw/rtl/bpf_pkg.sv @@
// Package with the shared widths, codes and payload types of the balloon pressure force block.
`default_nettype none
package bpf_pkg;

   localparam int INTENSITY_BITS = 16;
   localparam int FRAC_BITS      = 14;
   localparam int NORMAL_BITS    = 16;
   localparam int OUT_BITS       = 16;
   localparam int SIGMA_BITS     = 15;
   localparam int RECIP_BITS     = 24;
   localparam int RECIP_FRAC     = 22;
   localparam int MODE_BITS      = 2;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_INDEX_BITS = 2;

   localparam int D4_BITS  = INTENSITY_BITS + 3;
   localparam int CMP_BITS = ((D4_BITS > SIGMA_BITS + 4) ? D4_BITS : SIGMA_BITS + 4) + 2;
   localparam int MAG_BITS = SIGMA_BITS + 3;
   localparam int PROD_BITS = MAG_BITS + RECIP_BITS;
   localparam int P_BITS   = FRAC_BITS + 2;
   localparam int FP_BITS  = P_BITS + NORMAL_BITS;

   localparam logic [MODE_BITS-1:0] SHAPE_RECT = 2'd0;
   localparam logic [MODE_BITS-1:0] SHAPE_TRI  = 2'd1;
   localparam logic [MODE_BITS-1:0] SHAPE_TRAP = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MODE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MEAN  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIGMA = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RECIP = 2'd3;

   localparam logic [MODE_BITS-1:0]       MODE_RESET  = SHAPE_TRI;
   localparam logic [INTENSITY_BITS-1:0]  MEAN_RESET  = '0;
   localparam logic [SIGMA_BITS-1:0]      SIGMA_RESET = SIGMA_BITS'(1);
   localparam logic [RECIP_BITS-1:0]      RECIP_RESET = RECIP_BITS'(5592405);

   typedef struct packed {
      logic [MODE_BITS-1:0]             mode;
      logic signed [INTENSITY_BITS-1:0] mean;
      logic [SIGMA_BITS-1:0]            sigma;
      logic [RECIP_BITS-1:0]            recip;
   } cfg_type;

   typedef struct packed {
      logic signed [INTENSITY_BITS-1:0] intensity;
      logic signed [NORMAL_BITS-1:0]    normal_x;
      logic signed [NORMAL_BITS-1:0]    normal_y;
      logic signed [NORMAL_BITS-1:0]    normal_z;
   } req_type;

   typedef struct packed {
      logic signed [P_BITS-1:0]      pressure;
      logic signed [NORMAL_BITS-1:0] normal_x;
      logic signed [NORMAL_BITS-1:0] normal_y;
      logic signed [NORMAL_BITS-1:0] normal_z;
   } mid_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] pressure;
      logic signed [OUT_BITS-1:0] force_x;
      logic signed [OUT_BITS-1:0] force_y;
      logic signed [OUT_BITS-1:0] force_z;
   } rsp_type;

endpackage
`default_nettype wire

@@ hw/rtl/bpf_csr.sv @@
// Configuration registers of the balloon pressure force block behind an APB-style port.
`default_nettype none
module bpf_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [bpf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [bpf_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [bpf_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                   pready,
   output bpf_pkg::cfg_type                       cfg
);

   bpf_pkg::cfg_type cfg_ff;
   bpf_pkg::cfg_type cfg_in;
   logic [bpf_pkg::CSR_INDEX_BITS-1:0] index;
   logic write_en;

   assign index    = paddr[bpf_pkg::CSR_ADDR_BITS-1:2];
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            bpf_pkg::REG_MODE:  cfg_in.mode  = pwdata[bpf_pkg::MODE_BITS-1:0];
            bpf_pkg::REG_MEAN:  cfg_in.mean  = pwdata[bpf_pkg::INTENSITY_BITS-1:0];
            bpf_pkg::REG_SIGMA: cfg_in.sigma = pwdata[bpf_pkg::SIGMA_BITS-1:0];
            bpf_pkg::REG_RECIP: cfg_in.recip = pwdata[bpf_pkg::RECIP_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         bpf_pkg::REG_MODE:  prdata = bpf_pkg::CSR_DATA_BITS'(cfg_ff.mode);
         bpf_pkg::REG_MEAN:  prdata = bpf_pkg::CSR_DATA_BITS'(unsigned'(cfg_ff.mean));
         bpf_pkg::REG_SIGMA: prdata = bpf_pkg::CSR_DATA_BITS'(cfg_ff.sigma);
         bpf_pkg::REG_RECIP: prdata = bpf_pkg::CSR_DATA_BITS'(cfg_ff.recip);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode  <= bpf_pkg::MODE_RESET;
         cfg_ff.mean  <= bpf_pkg::MEAN_RESET;
         cfg_ff.sigma <= bpf_pkg::SIGMA_RESET;
         cfg_ff.recip <= bpf_pkg::RECIP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/bpf_pressure.sv @@
// Three-stage pipeline that turns an intensity sample into the pressure scalar.
`default_nettype none
module bpf_pressure (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bpf_pkg::cfg_type cfg,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire bpf_pkg::req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output bpf_pkg::mid_type      out_data
);

   localparam int CMP  = bpf_pkg::CMP_BITS;
   localparam int PB   = bpf_pkg::P_BITS;
   localparam int SH_TRI  = bpf_pkg::RECIP_FRAC + 3;
   localparam int SH_TRAP = bpf_pkg::RECIP_FRAC + 2;
   localparam int RND_BITS = bpf_pkg::PROD_BITS + bpf_pkg::FRAC_BITS + 1;
   localparam logic signed [PB-1:0] P_ONE = PB'(1) <<< bpf_pkg::FRAC_BITS;
   localparam logic signed [PB-1:0] P_MINUS_ONE = -P_ONE;
   localparam logic [RND_BITS-1:0] R_ONE     = RND_BITS'(1) << bpf_pkg::FRAC_BITS;
   localparam logic [RND_BITS-1:0] LIM_TRI   = RND_BITS'(1) << SH_TRI;
   localparam logic [RND_BITS-1:0] LIM_TRAP  = RND_BITS'(1) << SH_TRAP;
   localparam logic [RND_BITS-1:0] HALF_TRI  = RND_BITS'(1) << (SH_TRI - 1);
   localparam logic [RND_BITS-1:0] HALF_TRAP = RND_BITS'(1) << (SH_TRAP - 1);

   typedef struct packed {
      logic                             is_ramp;
      logic                             tri_ramp;
      logic                             neg;
      logic [bpf_pkg::MAG_BITS-1:0]     mag;
      logic signed [PB-1:0]             fixed_p;
      logic signed [bpf_pkg::NORMAL_BITS-1:0] nx;
      logic signed [bpf_pkg::NORMAL_BITS-1:0] ny;
      logic signed [bpf_pkg::NORMAL_BITS-1:0] nz;
   } sa_type;

   typedef struct packed {
      logic                             is_ramp;
      logic                             tri_ramp;
      logic                             neg;
      logic [bpf_pkg::PROD_BITS-1:0]    prod;
      logic signed [PB-1:0]             fixed_p;
      logic signed [bpf_pkg::NORMAL_BITS-1:0] nx;
      logic signed [bpf_pkg::NORMAL_BITS-1:0] ny;
      logic signed [bpf_pkg::NORMAL_BITS-1:0] nz;
   } sb_type;

   logic va_ff, vb_ff, vc_ff;
   logic ready_a, ready_b, ready_c;
   sa_type sa_ff, sa_in;
   sb_type sb_ff, sb_in;
   bpf_pkg::mid_type sc_ff, sc_in;

   logic signed [CMP-1:0] x_w, mean_w, s_w, d4, s3, s6, s9, s12, n4, abs_n4;
   logic [RND_BITS-1:0] prod_ext, rnd_tri, rnd_trap, rnd, lim;
   logic [RND_BITS-1:0] mag_r;
   logic signed [PB-1:0] ramp_p;

   assign ready_c  = !vc_ff || !out_stall;
   assign ready_b  = !vb_ff || ready_c;
   assign ready_a  = !va_ff || ready_b;
   assign in_stall = !ready_a;
   assign out_valid = vc_ff;
   assign out_data  = sc_ff;

   always_comb begin
      x_w    = CMP'(in_data.intensity);
      mean_w = CMP'(cfg.mean);
      s_w    = $signed({{(CMP - bpf_pkg::SIGMA_BITS){1'b0}}, cfg.sigma});
      d4     = (x_w - mean_w) <<< 2;
      s3     = (s_w <<< 1) + s_w;
      s6     = s3 <<< 1;
      s9     = s6 + s3;
      s12    = s6 <<< 1;
      n4     = (d4 < 0) ? (d4 + s6) : (s6 - d4);
      sa_in.is_ramp  = 1'b0;
      sa_in.tri_ramp = 1'b0;
      sa_in.fixed_p  = '0;
      case (cfg.mode)
         bpf_pkg::SHAPE_RECT: begin
            sa_in.fixed_p = (d4 < -s6 || d4 > s6) ? P_MINUS_ONE : P_ONE;
         end
         bpf_pkg::SHAPE_TRI: begin
            if (d4 < -s12 || d4 > s12) begin
               sa_in.fixed_p = P_MINUS_ONE;
            end else begin
               sa_in.is_ramp  = 1'b1;
               sa_in.tri_ramp = 1'b1;
            end
         end
         bpf_pkg::SHAPE_TRAP: begin
            if (d4 < -s9 || d4 > s9) begin
               sa_in.fixed_p = P_MINUS_ONE;
            end else if (d4 >= -s3 && d4 < s3) begin
               sa_in.fixed_p = P_ONE;
            end else begin
               sa_in.is_ramp = 1'b1;
            end
         end
         default: sa_in.fixed_p = '0;
      endcase
      sa_in.neg = n4[CMP-1];
      abs_n4    = sa_in.neg ? -n4 : n4;
      sa_in.mag = abs_n4[bpf_pkg::MAG_BITS-1:0];
      sa_in.nx  = in_data.normal_x;
      sa_in.ny  = in_data.normal_y;
      sa_in.nz  = in_data.normal_z;
   end

   always_comb begin
      sb_in.is_ramp  = sa_ff.is_ramp;
      sb_in.tri_ramp = sa_ff.tri_ramp;
      sb_in.neg      = sa_ff.neg;
      sb_in.prod     = bpf_pkg::PROD_BITS'(sa_ff.mag) * bpf_pkg::PROD_BITS'(cfg.recip);
      sb_in.fixed_p  = sa_ff.fixed_p;
      sb_in.nx       = sa_ff.nx;
      sb_in.ny       = sa_ff.ny;
      sb_in.nz       = sa_ff.nz;
   end

   always_comb begin
      prod_ext = RND_BITS'(sb_ff.prod);
      rnd_tri  = ((prod_ext << bpf_pkg::FRAC_BITS) + HALF_TRI) >> SH_TRI;
      rnd_trap = ((prod_ext << bpf_pkg::FRAC_BITS) + HALF_TRAP) >> SH_TRAP;
      rnd      = sb_ff.tri_ramp ? rnd_tri : rnd_trap;
      lim      = sb_ff.tri_ramp ? LIM_TRI : LIM_TRAP;
      if (prod_ext >= lim || rnd > R_ONE) begin
         mag_r = R_ONE;
      end else begin
         mag_r = rnd;
      end
      ramp_p = sb_ff.neg ? -$signed(mag_r[PB-1:0]) : $signed(mag_r[PB-1:0]);
      sc_in.pressure = sb_ff.is_ramp ? ramp_p : sb_ff.fixed_p;
      sc_in.normal_x = sb_ff.nx;
      sc_in.normal_y = sb_ff.ny;
      sc_in.normal_z = sb_ff.nz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            va_ff <= in_valid;
         end
         if (ready_b) begin
            vb_ff <= va_ff;
         end
         if (ready_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         sa_ff <= sa_in;
      end
      if (ready_b && va_ff) begin
         sb_ff <= sb_in;
      end
      if (ready_c && vb_ff) begin
         sc_ff <= sc_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/bpf_force.sv @@
// Two-stage pipeline that scales the normal by the pressure and saturates the result.
`default_nettype none
module bpf_force (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire bpf_pkg::mid_type in_data,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output bpf_pkg::rsp_type      out_data
);

   localparam int FB = bpf_pkg::FP_BITS;
   localparam logic [FB-1:0] F_ONE  = FB'(1) << bpf_pkg::FRAC_BITS;
   localparam logic [FB-1:0] F_HALF = FB'(1) << (bpf_pkg::FRAC_BITS - 1);

   typedef struct packed {
      logic signed [bpf_pkg::P_BITS-1:0] pressure;
      logic signed [FB-1:0]              px;
      logic signed [FB-1:0]              py;
      logic signed [FB-1:0]              pz;
   } sd_type;

   function automatic logic [bpf_pkg::OUT_BITS-1:0] round_sat(input logic signed [FB-1:0] prod);
      logic          neg;
      logic [FB-1:0] mag;
      logic [FB-1:0] r;
      logic [FB-1:0] s;
      neg = prod[FB-1];
      mag = neg ? unsigned'(-prod) : unsigned'(prod);
      r   = (mag + F_HALF) >> bpf_pkg::FRAC_BITS;
      if (r > F_ONE) begin
         r = F_ONE;
      end
      s = neg ? -r : r;
      return s[bpf_pkg::OUT_BITS-1:0];
   endfunction

   logic vd_ff, ve_ff;
   logic ready_d, ready_e;
   sd_type sd_ff, sd_in;
   bpf_pkg::rsp_type se_ff, se_in;

   assign ready_e   = !ve_ff || !out_stall;
   assign ready_d   = !vd_ff || ready_e;
   assign in_stall  = !ready_d;
   assign out_valid = ve_ff;
   assign out_data  = se_ff;

   always_comb begin
      sd_in.pressure = in_data.pressure;
      sd_in.px = FB'(in_data.pressure) * FB'(in_data.normal_x);
      sd_in.py = FB'(in_data.pressure) * FB'(in_data.normal_y);
      sd_in.pz = FB'(in_data.pressure) * FB'(in_data.normal_z);
   end

   always_comb begin
      se_in.pressure = bpf_pkg::OUT_BITS'(sd_ff.pressure);
      se_in.force_x  = round_sat(sd_ff.px);
      se_in.force_y  = round_sat(sd_ff.py);
      se_in.force_z  = round_sat(sd_ff.pz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         if (ready_d) begin
            vd_ff <= in_valid;
         end
         if (ready_e) begin
            ve_ff <= vd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_d && in_valid) begin
         sd_ff <= sd_in;
      end
      if (ready_e && vd_ff) begin
         se_ff <= se_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/balloon_pressure_force_top.sv @@
// Top level of the balloon pressure force block: registers, pressure pipeline and force pipeline.
//
//   Channel   Ports                    Payload      Direction
//   request   req_valid / req_stall    req_type     in
//   result    rsp_valid / rsp_stall    rsp_type     out
//   config    psel penable pwrite ...  32-bit APB   in
//
// A request enters every cycle while req_stall is low, and results leave one per cycle while
// rsp_stall is low. A request passes five register stages: decode, ramp multiply, ramp rounding,
// normal multiply and force rounding.
// Reset clears all valid bits and loads the register defaults; no clearing pass is needed.
// A stall holds only the stages that are full, so bubbles close up and nothing is lost.
`default_nettype none
module balloon_pressure_force_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire bpf_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output bpf_pkg::rsp_type                       rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [bpf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [bpf_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [bpf_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                   pready
);

   bpf_pkg::cfg_type cfg;
   bpf_pkg::mid_type mid_data;
   logic mid_valid;
   logic mid_stall;

   bpf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bpf_pressure u_pressure (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (mid_valid),
      .out_stall (mid_stall),
      .out_data  (mid_data)
   );

   bpf_force u_force (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_stall  (mid_stall),
      .in_data   (mid_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the balloon pressure force block.
`timescale 1ns / 1ps
module tb;

   typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_style_type;

   localparam logic [bpf_pkg::MODE_BITS-1:0] SHAPE_UNUSED = 2'd3;
   localparam logic [bpf_pkg::MODE_BITS-1:0] EVERY_SHAPE [4] =
      '{bpf_pkg::SHAPE_RECT, bpf_pkg::SHAPE_TRI, bpf_pkg::SHAPE_TRAP, SHAPE_UNUSED};
   localparam longint UNITY           = longint'(1) << bpf_pkg::FRAC_BITS;
   localparam int     PIPE_LATENCY    = 5;
   localparam int     RANDOM_PHASES   = 16;
   localparam int     ITEMS_PER_PHASE = 95;
   localparam int     CYCLE_LIMIT     = 300000;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   bpf_pkg::req_type                   req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   bpf_pkg::rsp_type                   rsp_data;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [bpf_pkg::CSR_ADDR_BITS-1:0]  paddr = '0;
   logic [bpf_pkg::CSR_DATA_BITS-1:0]  pwdata = '0;
   logic [bpf_pkg::CSR_DATA_BITS-1:0]  prdata;
   logic                               pready;

   bpf_pkg::cfg_type shadow_cfg = '{mode: bpf_pkg::MODE_RESET, mean: bpf_pkg::MEAN_RESET,
                                    sigma: bpf_pkg::SIGMA_RESET,
                                    recip: bpf_pkg::RECIP_RESET};
   bpf_pkg::rsp_type expected_forces[$];
   int               mismatch_count = 0;
   int               requests_sent = 0;
   int               settings_applied = 0;
   int               cycle_count = 0;
   int               burst_left = 0;
   int               stall_left = 0;
   idle_style_type   gap_style = IDLE_LIGHT;
   idle_style_type   stall_style = IDLE_LIGHT;

   balloon_pressure_force_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("balloon_pressure_force_top: mismatch");
         $finish;
      end
   end

   function automatic longint ramp_level(longint numer4, int extra_shift);
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned level;
      int              shift;
      shift = bpf_pkg::RECIP_FRAC + extra_shift;
      mag = (numer4 < 0) ? -numer4 : numer4;
      prod = mag * 64'(shadow_cfg.recip);
      if (prod >= (64'd1 << shift)) begin
         level = UNITY;
      end else begin
         level = ((prod << bpf_pkg::FRAC_BITS) + (64'd1 << (shift - 1))) >> shift;
         if (level > UNITY) level = UNITY;
      end
      return (numer4 < 0) ? -longint'(level) : longint'(level);
   endfunction

   function automatic longint pressure_level(
         logic signed [bpf_pkg::INTENSITY_BITS-1:0] sample);
      longint d4;
      longint s;
      d4 = 4 * (longint'($signed(sample)) - longint'($signed(shadow_cfg.mean)));
      s = longint'(shadow_cfg.sigma);
      case (shadow_cfg.mode)
         bpf_pkg::SHAPE_RECT: begin
            return (d4 < -6 * s || d4 > 6 * s) ? -UNITY : UNITY;
         end
         bpf_pkg::SHAPE_TRI: begin
            if (d4 < -12 * s || d4 > 12 * s) return -UNITY;
            return (d4 < 0) ? ramp_level(d4 + 6 * s, 3) : ramp_level(6 * s - d4, 3);
         end
         bpf_pkg::SHAPE_TRAP: begin
            if (d4 < -9 * s || d4 > 9 * s) return -UNITY;
            if (d4 < -3 * s) return ramp_level(d4 + 6 * s, 2);
            if (d4 < 3 * s) return UNITY;
            return ramp_level(6 * s - d4, 2);
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   function automatic longint scaled_force(longint level,
                                           logic signed [bpf_pkg::NORMAL_BITS-1:0] normal);
      longint          prod;
      longint unsigned mag;
      longint unsigned rounded;
      prod = level * longint'($signed(normal));
      mag = (prod < 0) ? -prod : prod;
      rounded = (mag + (64'd1 << (bpf_pkg::FRAC_BITS - 1))) >> bpf_pkg::FRAC_BITS;
      if (rounded > UNITY) rounded = UNITY;
      return (prod < 0) ? -longint'(rounded) : longint'(rounded);
   endfunction

   function automatic bpf_pkg::rsp_type predict_result(bpf_pkg::req_type item);
      bpf_pkg::rsp_type result;
      longint           level;
      level = pressure_level(item.intensity);
      result.pressure = bpf_pkg::OUT_BITS'(level);
      result.force_x = bpf_pkg::OUT_BITS'(scaled_force(level, item.normal_x));
      result.force_y = bpf_pkg::OUT_BITS'(scaled_force(level, item.normal_y));
      result.force_z = bpf_pkg::OUT_BITS'(scaled_force(level, item.normal_z));
      return result;
   endfunction

   function automatic logic [bpf_pkg::RECIP_BITS-1:0] recip_for(
         logic [bpf_pkg::SIGMA_BITS-1:0] sigma);
      longint three_s;
      three_s = 3 * longint'(sigma);
      if (three_s == 0) return '0;
      return bpf_pkg::RECIP_BITS'(((longint'(1) << (bpf_pkg::RECIP_FRAC + 2)) + three_s / 2)
                                  / three_s);
   endfunction

   function automatic logic signed [bpf_pkg::INTENSITY_BITS-1:0] clamp_intensity(
         longint value);
      if (value < -32768) return 16'sh8000;
      if (value > 32767) return 16'sh7FFF;
      return bpf_pkg::INTENSITY_BITS'(value);
   endfunction

   function automatic logic signed [bpf_pkg::NORMAL_BITS-1:0] random_normal();
      if ($urandom_range(0, 7) == 0) return bpf_pkg::NORMAL_BITS'($urandom);
      return bpf_pkg::NORMAL_BITS'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   always @(posedge clock) begin
      bpf_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_forces.size() == 0) begin
            $error("result with no request outstanding: %h", rsp_data);
            mismatch_count++;
         end else begin
            want = expected_forces.pop_front();
            if (rsp_data.pressure !== want.pressure) begin
               $error("pressure: expected %0d, got %0d", want.pressure, rsp_data.pressure);
               mismatch_count++;
            end
            if (rsp_data.force_x !== want.force_x) begin
               $error("force_x: expected %0d, got %0d", want.force_x, rsp_data.force_x);
               mismatch_count++;
            end
            if (rsp_data.force_y !== want.force_y) begin
               $error("force_y: expected %0d, got %0d", want.force_y, rsp_data.force_y);
               mismatch_count++;
            end
            if (rsp_data.force_z !== want.force_z) begin
               $error("force_z: expected %0d, got %0d", want.force_z, rsp_data.force_z);
               mismatch_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         case (stall_style)
            IDLE_NONE: begin
               rsp_stall <= 1'b0;
            end
            IDLE_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_stall <= ~rsp_stall;
               stall_left = $urandom_range(0, 15);
            end
         endcase
      end
   end

   task automatic send_request(input bpf_pkg::req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case (gap_style)
            IDLE_NONE: begin
               gap = 0;
            end
            IDLE_LIGHT: begin
               gap = $urandom_range(0, 2);
            end
            default: begin
               gap = $urandom_range(0, 10);
            end
         endcase
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_forces.push_back(predict_result(item));
      requests_sent++;
   endtask

   task automatic send_at(input longint offset, input int normal);
      bpf_pkg::req_type item;
      item.intensity = clamp_intensity(longint'($signed(shadow_cfg.mean)) + offset);
      item.normal_x = bpf_pkg::NORMAL_BITS'(normal);
      item.normal_y = ~bpf_pkg::NORMAL_BITS'(normal);
      item.normal_z = random_normal();
      send_request(item);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_forces.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   task automatic write_register(input logic [bpf_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [bpf_pkg::CSR_DATA_BITS-1:0] value);
      logic [bpf_pkg::CSR_DATA_BITS-1:0] mask;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (index)
         bpf_pkg::REG_MODE: begin
            shadow_cfg.mode = value[bpf_pkg::MODE_BITS-1:0];
            mask = (32'd1 << bpf_pkg::MODE_BITS) - 1;
         end
         bpf_pkg::REG_MEAN: begin
            shadow_cfg.mean = value[bpf_pkg::INTENSITY_BITS-1:0];
            mask = (32'd1 << bpf_pkg::INTENSITY_BITS) - 1;
         end
         bpf_pkg::REG_SIGMA: begin
            shadow_cfg.sigma = value[bpf_pkg::SIGMA_BITS-1:0];
            mask = (32'd1 << bpf_pkg::SIGMA_BITS) - 1;
         end
         default: begin
            shadow_cfg.recip = value[bpf_pkg::RECIP_BITS-1:0];
            mask = (32'd1 << bpf_pkg::RECIP_BITS) - 1;
         end
      endcase
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if ((prdata & mask) !== (value & mask)) begin
         $error("register %0d readback: expected %0h, got %0h", index, value & mask,
                prdata & mask);
         mismatch_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [bpf_pkg::MODE_BITS-1:0] mode,
                                 input logic signed [bpf_pkg::INTENSITY_BITS-1:0] mean,
                                 input logic [bpf_pkg::SIGMA_BITS-1:0] sigma,
                                 input logic [bpf_pkg::RECIP_BITS-1:0] recip);
      drain_pipeline();
      write_register(bpf_pkg::REG_MODE, bpf_pkg::CSR_DATA_BITS'(mode));
      write_register(bpf_pkg::REG_MEAN, bpf_pkg::CSR_DATA_BITS'($signed(mean)));
      write_register(bpf_pkg::REG_SIGMA, bpf_pkg::CSR_DATA_BITS'(sigma));
      write_register(bpf_pkg::REG_RECIP, bpf_pkg::CSR_DATA_BITS'(recip));
      settings_applied++;
   endtask

   task automatic test_reset_values();
      send_at(-32768, 16384);
      send_at(32767, -16384);
      send_at(0, 32767);
      send_at(2, -32768);
      send_at(-3, 0);
   endtask

   task automatic test_shape_boundaries();
      apply_settings(bpf_pkg::SHAPE_RECT, 16'sd100, 15'd4, recip_for(15'd4));
      send_at(-6, 16384);
      send_at(-7, -16384);
      send_at(6, 32767);
      send_at(7, -32768);
      apply_settings(bpf_pkg::SHAPE_TRI, 16'sd100, 15'd4, recip_for(15'd4));
      send_at(-13, 16384);
      send_at(-12, -16384);
      send_at(-5, 12345);
      send_at(0, -32768);
      send_at(12, 32767);
      apply_settings(bpf_pkg::SHAPE_TRAP, 16'sd100, 15'd4, recip_for(15'd4));
      send_at(-10, 16384);
      send_at(-9, -16384);
      send_at(-4, 9999);
      send_at(-3, -9999);
      send_at(2, 32767);
      send_at(3, -32768);
      send_at(9, 16384);
      apply_settings(SHAPE_UNUSED, 16'sd100, 15'd4, recip_for(15'd4));
      send_at(0, 16384);
      send_at(5, 32767);
   endtask

   task automatic test_special_registers();
      apply_settings(bpf_pkg::SHAPE_TRAP, -16'sd200, 15'd0, 24'd0);
      send_at(0, 16384);
      send_at(1, -16384);
      apply_settings(bpf_pkg::SHAPE_TRI, 16'sd0, 15'd4, 24'hFFFFFF);
      send_at(-5, 32767);
      send_at(3, -32768);
   endtask

   task automatic test_random_phases();
      logic [bpf_pkg::MODE_BITS-1:0]             mode;
      logic signed [bpf_pkg::INTENSITY_BITS-1:0] mean;
      logic [bpf_pkg::SIGMA_BITS-1:0]            sigma;
      logic [bpf_pkg::RECIP_BITS-1:0]            recip;
      longint                                    span;
      bpf_pkg::req_type                          item;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 4) mode = EVERY_SHAPE[phase];
         else if ($urandom_range(0, 7) == 0) mode = SHAPE_UNUSED;
         else mode = EVERY_SHAPE[$urandom_range(0, 2)];
         case (phase)
            4: mean = 16'sh8000;
            5: mean = 16'sh7FFF;
            default: mean = bpf_pkg::INTENSITY_BITS'($urandom);
         endcase
         case (phase)
            6: sigma = 15'd1;
            7: sigma = 15'd32767;
            8: sigma = 15'd0;
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  sigma = bpf_pkg::SIGMA_BITS'($urandom_range(1, 32767));
               end else begin
                  sigma = bpf_pkg::SIGMA_BITS'($urandom_range(1, 200));
               end
            end
         endcase
         case (phase)
            9: recip = '0;
            10: recip = '1;
            11: recip = bpf_pkg::RECIP_BITS'($urandom);
            default: recip = recip_for(sigma);
         endcase
         apply_settings(mode, mean, sigma, recip);
         gap_style = idle_style_type'(phase % 3);
         stall_style = idle_style_type'((phase / 3) % 3);
         span = (7 * longint'(sigma)) / 2 + 2;
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 3) != 0) begin
               item.intensity = clamp_intensity(longint'($signed(mean)) +
                                                longint'($urandom_range(0, 32'(2 * span)))
                                                - span);
            end else begin
               item.intensity = bpf_pkg::INTENSITY_BITS'($urandom);
            end
            item.normal_x = random_normal();
            item.normal_y = random_normal();
            item.normal_z = random_normal();
            send_request(item);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_shape_boundaries();
      test_special_registers();
      test_random_phases();
      drain_pipeline();
      $display("Ran %0d requests under %0d register settings: all shape codes, zero and",
               requests_sent, settings_applied);
      $display("full-range sigma, bad reciprocals, extreme normals, idling on both sides.");
      if (mismatch_count == 0 && expected_forces.size() == 0) begin
         $display("balloon_pressure_force_top: match");
      end else begin
         $display("balloon_pressure_force_top: mismatch");
      end
      $finish;
   end

endmodule
